// ===== rtl/core/wfba_pkg.sv =====
// Shared types and codes for the worst-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none
package wfba_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_LOAD_OK   = 2'd0,
        ST_LOAD_FULL = 2'd1,
        ST_ALLOC_OK  = 2'd2,
        ST_NO_FIT    = 2'd3
    } status_t;

    // Port controls of the size table memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/worst_fit_block_allocator.sv =====
// Worst-fit block allocator: load sizes into a table and allocate from the largest fit.
// Load beat: result strobe (done) in the cycle after start; busy stays low.
// Allocate beat: busy through the scan, drain and update states (one table read per cycle through the
//   memory's single read port), result on done as busy drops; empty table: done in the cycle after start.
// One result per accepted beat, shown for exactly one cycle; the receiver cannot stall.
// Reset (rst_n low, async) empties the table and clears control; table contents stay unset.
`timescale 1ns / 1ps
`default_nettype none
module worst_fit_block_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         req_type,
    input  wire  [15:0] amount,
    output logic        done,
    output logic [1:0]  status,
    output logic [4:0]  block_number,
    output logic [15:0] remaining_size
);
    import wfba_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int EXT_W = SIZE_BITS + 16;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [15:0]          amt_reg, amt_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_size_reg, best_size_next;
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [4:0]           number_reg, number_next;
    logic [15:0]          remain_reg, remain_next;

    mem_cmd_t             mem_cmd;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic [SIZE_BITS-1:0] mem_rdata;

    logic [EXT_W-1:0]     rd_ext;
    logic [EXT_W-1:0]     amt_ext;
    logic [EXT_W-1:0]     best_ext;
    logic [EXT_W-1:0]     load_ext;
    logic [EXT_W-1:0]     diff_ext;
    logic [CNT_W+4:0]     load_num_ext;
    logic [IDX_W+4:0]     best_num_ext;
    logic                 fits;
    logic                 better;
    logic                 last_addr;
    logic                 table_full;

    // Size table memory
    wfba_ram #(
        .DEPTH  (MAX_BLOCKS),
        .WIDTH  (SIZE_BITS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .cmd   (mem_cmd),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    // Widen operands so the request is compared at full width
    assign rd_ext       = {16'd0, mem_rdata};
    assign best_ext     = {16'd0, best_size_reg};
    assign amt_ext      = {{SIZE_BITS{1'b0}}, amt_reg};
    assign load_ext     = {{SIZE_BITS{1'b0}}, amount};
    assign diff_ext     = best_ext - amt_ext;
    assign load_num_ext = {5'd0, count_reg + CNT_W'(1)};
    assign best_num_ext = {4'd0, {1'b0, best_idx_reg} + (IDX_W + 1)'(1)};
    assign fits         = (rd_ext >= amt_ext);
    assign better       = !found_reg || (mem_rdata > best_size_reg);
    assign last_addr    = ((CNT_W'(addr_reg) + CNT_W'(1)) == count_reg);
    assign table_full   = (count_reg == CNT_W'(MAX_BLOCKS));

    // Next-state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = addr_reg;
        amt_next       = amt_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        number_next    = number_reg;
        remain_next    = remain_reg;
        mem_cmd        = '0;
        mem_waddr      = best_idx_reg;
        mem_wdata      = diff_ext[SIZE_BITS-1:0];

        // Compare the entry whose read data just arrived
        if (chk_valid_reg && fits && better)
        begin
            found_next     = 1'b1;
            best_idx_next  = chk_idx_reg;
            best_size_next = mem_rdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!req_type)
                    begin
                        // Load: append at the next index, or reject when full
                        done_next = 1'b1;
                        if (table_full)
                        begin
                            status_next = ST_LOAD_FULL;
                            number_next = 5'd0;
                            remain_next = 16'd0;
                        end
                        else
                        begin
                            mem_cmd.wr_en = 1'b1;
                            mem_waddr     = count_reg[IDX_W-1:0];
                            mem_wdata     = load_ext[SIZE_BITS-1:0];
                            count_next    = count_reg + CNT_W'(1);
                            status_next   = ST_LOAD_OK;
                            number_next   = load_num_ext[4:0];
                            remain_next   = load_ext[15:0] & {{(16 - ((SIZE_BITS < 16) ?
                                            SIZE_BITS : 16)){1'b0}},
                                            {((SIZE_BITS < 16) ? SIZE_BITS : 16){1'b1}}};
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // Empty table: nothing fits
                        done_next   = 1'b1;
                        status_next = ST_NO_FIT;
                        number_next = 5'd0;
                        remain_next = 16'd0;
                    end
                    else
                    begin
                        amt_next   = amount;
                        addr_next  = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one read per cycle over the loaded entries
                mem_cmd.rd_en  = 1'b1;
                chk_valid_next = 1'b1;
                chk_idx_next   = addr_reg;
                if (last_addr)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                // Last read data is compared this cycle
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                // Shrink the chosen block and report it, or report no fit
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (found_reg)
                begin
                    mem_cmd.wr_en = 1'b1;
                    status_next   = ST_ALLOC_OK;
                    number_next   = best_num_ext[4:0];
                    remain_next   = diff_ext[15:0] & {{(16 - ((SIZE_BITS < 16) ?
                                    SIZE_BITS : 16)){1'b0}},
                                    {((SIZE_BITS < 16) ? SIZE_BITS : 16){1'b1}}};
                end
                else
                begin
                    status_next = ST_NO_FIT;
                    number_next = 5'd0;
                    remain_next = 16'd0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        chk_idx_reg   <= chk_idx_next;
        amt_reg       <= amt_next;
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
        status_reg    <= status_next;
        number_reg    <= number_next;
        remain_reg    <= remain_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign block_number   = number_reg;
    assign remaining_size = remain_reg;

endmodule
`default_nettype wire

// ===== rtl/core/wfba_ram.sv =====
// Simple dual-port size table memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wfba_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire                   clk,
    input  wfba_pkg::mem_cmd_t    cmd,
    input  wire  [ADDR_W-1:0]     waddr,
    input  wire  [WIDTH-1:0]      wdata,
    input  wire  [ADDR_W-1:0]     raddr,
    output logic [WIDTH-1:0]      rdata
);
    import wfba_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read the entry; the read data is registered
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
